>>> rtl/hbs_pkg.sv
// Shared constants, types and helpers for the height-map bilinear sampler.
package hbs_pkg;

  // Store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int GRID_MAX   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SIZE_W     = $clog2(GRID_MAX + 1);
  localparam int COORD_W    = $clog2(GRID_MAX);
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  // Field widths
  localparam int PIX_W    = 16;
  localparam int CH_W     = 8;
  localparam int POS_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W    = 9;
  localparam int WGT_W    = FRAC_W + 1;
  localparam int ROW_W    = 32;
  localparam int ACC_W    = 48;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLOUR_MODE  = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  // Item kinds
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Greyscale weights, sum 256
  localparam logic [HEIGHT_W-1:0] W_RED   = 16'd77;
  localparam logic [HEIGHT_W-1:0] W_GREEN = 16'd151;
  localparam logic [HEIGHT_W-1:0] W_BLUE  = 16'd28;

  localparam logic [WGT_W-1:0] WGT_ONE    = 17'h10000;
  localparam logic [ACC_W-1:0] ROUND_HALF = 48'h0000_8000_0000;

  // Floor and ceiling texel with the fraction between them
  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [FRAC_W-1:0]  frac;
  } grid_pt_t;

  // Saturate a size register to 1..max_v
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] cfg, input int max_v);
    logic [SIZE_W-1:0] res;
    if (cfg == '0) begin
      res = SIZE_W'(1);
    end else if (int'(cfg) > max_v) begin
      res = SIZE_W'(max_v);
    end else begin
      res = SIZE_W'(cfg);
    end
    return res;
  endfunction

endpackage

>>> rtl/hbs_height_ram.sv
// Single-port height store with registered read data.
module hbs_height_ram
  import hbs_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic                we,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [HEIGHT_W-1:0] wdata,
  output logic [HEIGHT_W-1:0] rdata
);

  logic [HEIGHT_W-1:0] mem [DEPTH];

  // One access per cycle, read returns old data
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/hbs_grid_map.sv
// Maps a Q1.15 position onto the texel grid: floor, clamped ceiling, fraction.
module hbs_grid_map
  import hbs_pkg::*;
(
  input  logic signed [POS_W-1:0] pos,
  input  logic [SIZE_W-1:0]       size,
  output grid_pt_t                pt
);

  localparam int PROD_W = POS_W + SIZE_W;
  localparam int CMP_W  = SIZE_W + 1;

  logic [POS_W-1:0]   u;
  logic [PROD_W-1:0]  prod;
  logic [COORD_W:0]   hi_inc;
  logic               at_edge;

  // Offset to unsigned [0,2) and scale by the size
  assign u      = {~pos[POS_W-1], pos[POS_W-2:0]};
  assign prod   = PROD_W'(u) * PROD_W'(size);
  assign pt.lo  = prod[FRAC_W +: COORD_W];
  assign pt.frac = prod[FRAC_W-1:0];

  // Ceiling steps one texel unless exact or already on the last one
  assign hi_inc  = {1'b0, pt.lo} + 1'b1;
  assign at_edge = CMP_W'(hi_inc) >= CMP_W'(size);
  assign pt.hi   = (pt.frac == '0 || at_edge) ? pt.lo : hi_inc[COORD_W-1:0];

endmodule

>>> rtl/heightmap_bilinear_sampler_unit.sv
// Top level of the height-map bilinear sampler.
//
// Input channel (in_valid/in_stall) carries one item per transaction: a load
// (func = 0) writes one pixel's grey level into the height store, a sample
// (func = 1) returns the bilinear height at x_pos/y_pos. Every item yields one
// result on the output channel (out_valid/out_stall): height and index_error.
// The configuration port (cfg_we/cfg_index/cfg_data) sets image width, image
// height and colour mode; write it only while no item is in flight.
//
// One item is processed at a time. A load goes from acceptance to the load
// step, which writes a valid index to the store and offers its result, then
// returns to idle. A sample passes through grid mapping, row base products,
// four texel reads through the single port of the height store, two row blends
// and the column blend, and offers its result from its final step. Results sit in an output
// register, so a new item is taken while the previous result is still stalled;
// the item then waits in its final step until the output register frees up.
// Reset clears the control state, holds the input stalled and restores width
// 256, height 256 and grey mode. The height store is not cleared: samples must
// only touch texels that were loaded before.
module heightmap_bilinear_sampler_unit
  import hbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    func,
  input  logic [PIX_W-1:0]        pixel_index,
  input  logic [CH_W-1:0]         red,
  input  logic [CH_W-1:0]         green,
  input  logic [CH_W-1:0]         blue,
  input  logic signed [POS_W-1:0] x_pos,
  input  logic signed [POS_W-1:0] y_pos,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HEIGHT_W-1:0]     height,
  output logic                    index_error,
  // configuration
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int CNT_W  = 2 * SIZE_W;
  localparam int BASE_W = COORD_W + SIZE_W;
  localparam int PA_W   = HEIGHT_W + WGT_W;
  localparam int PY_W   = ROW_W + WGT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MAP, ST_BASE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_ROW2, ST_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             colour_mode;

  // captured item
  logic [PIX_W-1:0]        idx_q;
  logic [CH_W-1:0]         red_q, green_q, blue_q;
  logic signed [POS_W-1:0] x_q, y_q;

  // sample datapath
  grid_pt_t            gx, gy, gx_q, gy_q;
  logic [ADDR_W-1:0]   base1, base2;
  logic [ROW_W-1:0]    row_acc, row1, row2;
  logic [ACC_W-1:0]    sum_acc;

  logic [SIZE_W-1:0]   w_eff, h_eff;
  logic [CNT_W-1:0]    pix_cnt;
  logic                idx_bad;
  logic [HEIGHT_W-1:0] load_val;
  logic                out_free;
  logic                out_load;
  logic [WGT_W-1:0]    wx0, wy0;
  logic [BASE_W-1:0]   base1_full, base2_full;
  logic [PA_W-1:0]     prod_a, prod_b;
  logic [PY_W-1:0]     prod_y0, prod_y1;
  logic [ACC_W-1:0]    sum_fin;

  logic                mem_en, mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [HEIGHT_W-1:0] mem_q;

  assign in_stall = rst || (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  // a result enters the output register this cycle
  assign out_load = out_free && (state == ST_LOAD || state == ST_OUT);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
      colour_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_COLOUR_MODE:  colour_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign w_eff = eff_size(image_width, MAX_WIDTH);
  assign h_eff = eff_size(image_height, MAX_HEIGHT);

  // Load path: index check and grey conversion
  assign pix_cnt  = CNT_W'(w_eff) * CNT_W'(h_eff);
  assign idx_bad  = 32'(idx_q) >= 32'(pix_cnt);
  assign load_val = colour_mode ? (HEIGHT_W'(red_q) * W_RED + HEIGHT_W'(green_q) * W_GREEN
                                   + HEIGHT_W'(blue_q) * W_BLUE)
                                : {red_q, CH_W'(0)};

  // Grid mapping for both axes
  hbs_grid_map u_map_x (.pos(x_q), .size(w_eff), .pt(gx));
  hbs_grid_map u_map_y (.pos(y_q), .size(h_eff), .pt(gy));

  assign base1_full = BASE_W'(gy_q.lo) * BASE_W'(w_eff);
  assign base2_full = BASE_W'(gy_q.hi) * BASE_W'(w_eff);

  // Blend weights and products
  assign wx0     = WGT_ONE - WGT_W'(gx_q.frac);
  assign wy0     = WGT_ONE - WGT_W'(gy_q.frac);
  assign prod_a  = PA_W'(mem_q) * PA_W'(wx0);
  assign prod_b  = PA_W'(mem_q) * PA_W'(gx_q.frac);
  assign prod_y0 = PY_W'(row1) * PY_W'(wy0);
  assign prod_y1 = PY_W'(row2) * PY_W'(gy_q.frac);
  assign sum_fin = sum_acc + prod_y1[ACC_W-1:0] + ROUND_HALF;

  // Store port selection
  always_comb begin
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = ADDR_W'(idx_q);
    unique case (state)
      ST_LOAD: begin
        mem_en = out_free;
        mem_we = out_free && !idx_bad;
      end
      ST_RD0: begin
        mem_en   = 1'b1;
        mem_addr = base1 + ADDR_W'(gx_q.lo);
      end
      ST_RD1: begin
        mem_en   = 1'b1;
        mem_addr = base1 + ADDR_W'(gx_q.hi);
      end
      ST_RD2: begin
        mem_en   = 1'b1;
        mem_addr = base2 + ADDR_W'(gx_q.lo);
      end
      ST_RD3: begin
        mem_en   = 1'b1;
        mem_addr = base2 + ADDR_W'(gx_q.hi);
      end
      default: ;
    endcase
  end

  hbs_height_ram u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (load_val),
    .rdata (mem_q)
  );

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            idx_q   <= pixel_index;
            red_q   <= red;
            green_q <= green;
            blue_q  <= blue;
            x_q     <= x_pos;
            y_q     <= y_pos;
            state   <= (func == FUNC_SAMPLE) ? ST_MAP : ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            height      <= '0;
            index_error <= idx_bad;
            state       <= ST_IDLE;
          end
        end
        ST_MAP: begin
          gx_q  <= gx;
          gy_q  <= gy;
          state <= ST_BASE;
        end
        ST_BASE: begin
          base1 <= base1_full[ADDR_W-1:0];
          base2 <= base2_full[ADDR_W-1:0];
          state <= ST_RD0;
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          row_acc <= prod_a[ROW_W-1:0];
          state   <= ST_RD2;
        end
        ST_RD2: begin
          row1  <= row_acc + prod_b[ROW_W-1:0];
          state <= ST_RD3;
        end
        ST_RD3: begin
          row_acc <= prod_a[ROW_W-1:0];
          sum_acc <= prod_y0[ACC_W-1:0];
          state   <= ST_ROW2;
        end
        ST_ROW2: begin
          row2  <= row_acc + prod_b[ROW_W-1:0];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            height      <= sum_fin[ACC_W-1 -: HEIGHT_W];
            index_error <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/hbs_checker.sv
// Port-level checks for the height-map bilinear sampler, bound to the top level.
module hbs_checker
  import hbs_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [HEIGHT_W-1:0]     height,
  input logic                    index_error
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(height) && $stable(index_error))
    else $error("result changed while stalled");

  // Only one item in flight: intake closes right after a transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  // A rejected load reports no height
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> height == '0)
    else $error("index error with nonzero height");

endmodule

bind heightmap_bilinear_sampler_unit hbs_checker u_hbs_checker (.*);
